/* src/dpfa_pkg.sv */
// Shared types and constants for the dining seat fork arbiter.
package dpfa_pkg;

  // Default ring size and the fixed widths of the stream fields.
  localparam int MAX_SEATS   = 8;
  localparam int CNT_W       = 4;
  localparam int SEAT_W      = 3;
  localparam int MASK_W      = 8;
  localparam logic [CNT_W-1:0] ACTIVE_SEATS_RESET = 4'd5;

  // Life cycle of one seat.
  typedef enum logic [1:0] {
    SEAT_THINKING = 2'd0,
    SEAT_HUNGRY   = 2'd1,
    SEAT_EATING   = 2'd2
  } seat_state_e;

  // Per-seat control decoded from the accepted request word.
  typedef struct packed {
    logic update;        // request accepted and seat index valid
    logic set_hungry;    // this seat asks for its forks
    logic set_thinking;  // this seat puts its forks down
    logic test_first;    // first eligibility test lands on this seat
    logic test_second;   // second test, after the first has taken effect
  } seat_ctrl_t;

endpackage

/* src/dpfa_seat_cell.sv */
// One seat of the ring: holds its state and hands its eating flags to its neighbours.
module dpfa_seat_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dpfa_pkg::seat_ctrl_t ctrl_i,
  input  logic                left_pre_eat_i,
  input  logic                right_pre_eat_i,
  input  logic                left_mid_eat_i,
  input  logic                right_mid_eat_i,
  output logic                pre_eat_o,
  output logic                mid_eat_o,
  output logic                grant_o,
  output logic                eating_o
);

  dpfa_pkg::seat_state_e state_q, state_d;
  dpfa_pkg::seat_state_e pre_state, mid_state;
  logic grant_first, grant_second;

  // The requesting seat changes first; the tests then see that change.
  always_comb begin
    if (ctrl_i.set_hungry) begin
      pre_state = dpfa_pkg::SEAT_HUNGRY;
    end else if (ctrl_i.set_thinking) begin
      pre_state = dpfa_pkg::SEAT_THINKING;
    end else begin
      pre_state = state_q;
    end
  end

  // First test uses the neighbours as they stand after the request update.
  assign grant_first = ctrl_i.test_first && (pre_state == dpfa_pkg::SEAT_HUNGRY) &&
                       !left_pre_eat_i && !right_pre_eat_i;
  assign mid_state   = grant_first ? dpfa_pkg::SEAT_EATING : pre_state;

  // Second test sees whatever the first test granted.
  assign grant_second = ctrl_i.test_second && (mid_state == dpfa_pkg::SEAT_HUNGRY) &&
                        !left_mid_eat_i && !right_mid_eat_i;
  assign state_d      = grant_second ? dpfa_pkg::SEAT_EATING : mid_state;

  assign pre_eat_o = (pre_state == dpfa_pkg::SEAT_EATING);
  assign mid_eat_o = (mid_state == dpfa_pkg::SEAT_EATING);
  assign grant_o   = grant_first || grant_second;
  assign eating_o  = (state_d == dpfa_pkg::SEAT_EATING);

  // Seat state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpfa_pkg::SEAT_THINKING;
    end else if (ctrl_i.update) begin
      state_q <= state_d;
    end
  end

endmodule

/* src/dining_philosophers_fork_arbiter_unit.sv */
// Top level of the dining seat fork arbiter: request decode, seat ring and result register.
//
// Requests arrive on the s_axis channel, one word per request: tuser carries the
// mode (0 take forks, 1 put forks) and tdata the seat index. Each word produces
// exactly one result word on m_axis: grant mask and eating mask in tdata, and in
// tuser a flag marking a seat index at or beyond the active seat count (such a
// request changes nothing and grants nobody).
// The seats form a row of cells that exchange their eating flags with their ring
// neighbours; a request is decoded, tested and written back in the cycle it is
// accepted, and its result is registered for the following cycle, so one request
// can be accepted every cycle while the receiver keeps up. The throughput is set
// by the single result register: a new word is taken whenever that register is
// empty or being drained, so a stalled receiver holds off the request side after one word.
// The cfg channel writes the active seat count (always ready); it should only be
// written while no request is outstanding. Reset sets every seat thinking and the
// seat count to five; no clearing pass is needed.
module dining_philosophers_fork_arbiter_unit #(
  parameter int MaxSeats = dpfa_pkg::MAX_SEATS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration: active seat count.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dpfa_pkg::CNT_W-1:0]   cfg_data_i,
  // Requests.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [2:0] seat_index
  input  logic [0:0]                   s_axis_tuser,   // [0] mode
  // Results.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [2*dpfa_pkg::MASK_W-1:0] m_axis_tdata,  // [7:0] grant_mask, [15:8] eating_mask
  output logic [0:0]                   m_axis_tuser    // [0] bad_seat
);

  localparam int CntW   = dpfa_pkg::CNT_W;
  localparam int MaskW  = dpfa_pkg::MASK_W;
  localparam int IdxW   = (MaxSeats > 1) ? $clog2(MaxSeats) : 1;
  localparam int CntMax = (MaxSeats < (2**CntW - 1)) ? MaxSeats : (2**CntW - 1);

  logic [CntW-1:0] active_q;
  logic [CntW-1:0] seat_cnt;
  logic [CntW-1:0] seat_ext, left_seat, right_seat;
  logic [IdxW-1:0] last_idx;
  logic            s_fire, bad_seat, mode, upd;

  logic [MaxSeats-1:0] pre_eat, mid_eat, grant_vec, eat_vec;
  logic [MaxSeats-1:0] left_pre, right_pre, left_mid, right_mid;
  dpfa_pkg::seat_ctrl_t [MaxSeats-1:0] ctrl;

  logic [MaskW-1:0] grant_mask, eating_mask;
  logic             m_valid_q;
  logic [2*MaskW-1:0] m_data_q;
  logic             m_user_q;

  // Configuration register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= dpfa_pkg::ACTIVE_SEATS_RESET;
    end else if (cfg_valid_i) begin
      active_q <= cfg_data_i;
    end
  end

  // Effective ring size, clamped to one and to the number of cells.
  always_comb begin
    if (active_q == '0) begin
      seat_cnt = CntW'(1);
    end else if (int'(active_q) > CntMax) begin
      seat_cnt = CntW'(CntMax);
    end else begin
      seat_cnt = active_q;
    end
  end
  assign last_idx = IdxW'(seat_cnt - CntW'(1));

  // Request decode: validity and the two ring neighbours of the seat.
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign mode          = s_axis_tuser[0];
  assign seat_ext      = {1'b0, s_axis_tdata[dpfa_pkg::SEAT_W-1:0]};
  assign bad_seat      = (seat_ext >= seat_cnt);
  assign upd           = s_fire && !bad_seat;
  assign left_seat     = (seat_ext == '0) ? (seat_cnt - CntW'(1)) : (seat_ext - CntW'(1));
  assign right_seat    = ((seat_ext + CntW'(1)) == seat_cnt) ? '0 : (seat_ext + CntW'(1));

  // Row of seat cells with wrap-around at the active count.
  for (genvar k = 0; k < MaxSeats; k++) begin : g_seat
    logic is_seat, is_left, is_right;

    assign is_seat  = (int'(seat_ext) == k);
    assign is_left  = (int'(left_seat) == k);
    assign is_right = (int'(right_seat) == k);

    assign ctrl[k].update       = upd;
    assign ctrl[k].set_hungry   = upd && !mode && is_seat;
    assign ctrl[k].set_thinking = upd && mode && is_seat;
    assign ctrl[k].test_first   = upd && (mode ? is_left : is_seat);
    assign ctrl[k].test_second  = upd && mode && is_right;

    if (k == 0) begin : g_first
      assign left_pre[k] = pre_eat[last_idx];
      assign left_mid[k] = mid_eat[last_idx];
    end else begin : g_inner_left
      assign left_pre[k] = pre_eat[k-1];
      assign left_mid[k] = mid_eat[k-1];
    end

    if (k == MaxSeats - 1) begin : g_end
      assign right_pre[k] = pre_eat[0];
      assign right_mid[k] = mid_eat[0];
    end else begin : g_inner_right
      logic is_last;
      assign is_last      = (int'(last_idx) == k);
      assign right_pre[k] = is_last ? pre_eat[0] : pre_eat[k+1];
      assign right_mid[k] = is_last ? mid_eat[0] : mid_eat[k+1];
    end

    dpfa_seat_cell u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .ctrl_i          (ctrl[k]),
      .left_pre_eat_i  (left_pre[k]),
      .right_pre_eat_i (right_pre[k]),
      .left_mid_eat_i  (left_mid[k]),
      .right_mid_eat_i (right_mid[k]),
      .pre_eat_o       (pre_eat[k]),
      .mid_eat_o       (mid_eat[k]),
      .grant_o         (grant_vec[k]),
      .eating_o        (eat_vec[k])
    );
  end

  // Result masks: only the first eight seats are visible, eating only inside the ring.
  for (genvar i = 0; i < MaskW; i++) begin : g_mask
    if (i < MaxSeats) begin : g_have
      assign grant_mask[i]  = grant_vec[i];
      assign eating_mask[i] = eat_vec[i] && (i < int'(seat_cnt));
    end else begin : g_none
      assign grant_mask[i]  = 1'b0;
      assign eating_mask[i] = 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      m_valid_q <= s_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      m_data_q <= {eating_mask, grant_mask};
      m_user_q <= bad_seat;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

`ifndef SYNTHESIS
  // A rejected seat index grants nobody.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && bad_seat |=> m_axis_tuser[0] && (m_axis_tdata[MaskW-1:0] == '0))
    else $error("bad seat request produced a grant");

  // Every granted seat is reported as eating.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[MaskW-1:0] & ~m_axis_tdata[2*MaskW-1:MaskW]) == '0))
    else $error("granted seat missing from eating mask");

  // A take request can only grant the requesting seat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !bad_seat && !mode |=> $onehot0(m_axis_tdata[MaskW-1:0]))
    else $error("take request granted more than one seat");

  // A put request grants at most its two neighbours.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !bad_seat && mode |=> ($countones(m_axis_tdata[MaskW-1:0]) <= 2))
    else $error("put request granted more than two seats");
`endif

endmodule
